### rtl/rtis_pkg.sv
// ----------------------------------------------------------------------------
// rtis_pkg: shared types and constants for ruler tick interval statistics
// Register indexes, configuration and event structures, field widths.
// ----------------------------------------------------------------------------
`default_nettype none

package rtis_pkg;

   localparam int MAX_COLUMNS = 4096;
   localparam int MAX_ROWS    = 4096;

   localparam int KIND_LEFT   = 0;
   localparam int KIND_RIGHT  = 1;
   localparam int KIND_CENTER = 2;
   localparam int KIND_COUNT  = 3;

   localparam int QUEUE_DEPTH = 4;
   localparam int QUEUE_PTR_W = $clog2(QUEUE_DEPTH);

   typedef enum logic [2:0] {
      CSR_DARK_THRESHOLD = 3'd0,
      CSR_BAND_FIRST_ROW = 3'd1,
      CSR_BAND_END_ROW   = 3'd2,
      CSR_WIDTH_MIN      = 3'd3,
      CSR_WIDTH_MAX      = 3'd4,
      CSR_SPACING_MIN    = 3'd5,
      CSR_SPACING_MAX    = 3'd6,
      CSR_UNUSED         = 3'd7
   } csr_index_type;

   typedef struct packed {
      logic [7:0]  dark_threshold;
      logic [11:0] band_first_row;
      logic [12:0] band_end_row;
      logic [12:0] width_min;
      logic [12:0] width_max;
      logic [12:0] spacing_min;
      logic [12:0] spacing_max;
   } cfg_type;

   typedef struct packed {
      logic                        frame_last;
      logic [KIND_COUNT-1:0]       hit;
      logic [KIND_COUNT-1:0][12:0] spacing;
   } event_type;

   typedef struct packed {
      logic                        frame_last;
      logic [KIND_COUNT-1:0]       hit;
      logic [KIND_COUNT-1:0][12:0] spacing;
      logic [KIND_COUNT-1:0][25:0] square;
   } square_stage_type;

   typedef struct packed {
      logic [KIND_COUNT-1:0][23:0] count;
      logic [KIND_COUNT-1:0][35:0] sum;
      logic [KIND_COUNT-1:0][47:0] square_sum;
   } totals_type;

endpackage

`default_nettype wire

### rtl/ruler_tick_interval_stats_top.sv
// ----------------------------------------------------------------------------
// ruler_tick_interval_stats_top: ruler tick spacing statistics over a frame
// Throughput is one pixel per cycle; the front run tracker takes a pixel
// every cycle while the four-entry event queue has room.
// From the frame's last pixel transfer to rsp_valid the event passes the queue
// entry, the squaring stage, then accumulate and result register.
// Synchronous reset loads register defaults and clears the running totals.
// ----------------------------------------------------------------------------
`default_nettype none

module ruler_tick_interval_stats_top
   import rtis_pkg::*;
(
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        csr_valid,
   output logic             csr_ready,
   input  wire logic [2:0]  csr_index,
   input  wire logic [12:0] csr_data,
   input  wire logic        req_valid,
   output logic             req_stall,
   input  wire logic [7:0]  req_red,
   input  wire logic [7:0]  req_green,
   input  wire logic [7:0]  req_blue,
   input  wire logic [11:0] req_column,
   input  wire logic [11:0] req_row,
   input  wire logic        req_row_last,
   input  wire logic        req_frame_last,
   output logic             rsp_valid,
   input  wire logic        rsp_stall,
   output logic [23:0]      rsp_left_count,
   output logic [35:0]      rsp_left_sum,
   output logic [47:0]      rsp_left_square_sum,
   output logic [23:0]      rsp_right_count,
   output logic [35:0]      rsp_right_sum,
   output logic [47:0]      rsp_right_square_sum,
   output logic [23:0]      rsp_center_count,
   output logic [35:0]      rsp_center_sum,
   output logic [47:0]      rsp_center_square_sum
);

   cfg_type    cfg_ff, cfg_in;
   logic       accept;
   logic       push;
   event_type  push_event;
   logic       queue_full;
   logic       pop;
   logic       head_valid;
   event_type  head_event;
   totals_type totals;

   assign csr_ready = 1'b1;

   always_comb begin
      cfg_in = cfg_ff;
      if (csr_valid && csr_ready) begin
         unique case (csr_index_type'(csr_index))
            CSR_DARK_THRESHOLD: cfg_in.dark_threshold = csr_data[7:0];
            CSR_BAND_FIRST_ROW: cfg_in.band_first_row = csr_data[11:0];
            CSR_BAND_END_ROW:   cfg_in.band_end_row = csr_data;
            CSR_WIDTH_MIN:      cfg_in.width_min = csr_data;
            CSR_WIDTH_MAX:      cfg_in.width_max = csr_data;
            CSR_SPACING_MIN:    cfg_in.spacing_min = csr_data;
            CSR_SPACING_MAX:    cfg_in.spacing_max = csr_data;
            default:            cfg_in = cfg_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.dark_threshold <= 8'd128;
         cfg_ff.band_first_row <= 12'd0;
         cfg_ff.band_end_row <= 13'd0;
         cfg_ff.width_min <= 13'd1;
         cfg_ff.width_max <= 13'd30;
         cfg_ff.spacing_min <= 13'd0;
         cfg_ff.spacing_max <= 13'd100;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   assign req_stall = queue_full;
   assign accept = req_valid && !req_stall;

   rtis_front u_front (
      .clock      (clock),
      .reset      (reset),
      .cfg        (cfg_ff),
      .accept     (accept),
      .red        (req_red),
      .green      (req_green),
      .blue       (req_blue),
      .column     (req_column),
      .row        (req_row),
      .row_last   (req_row_last),
      .frame_last (req_frame_last),
      .push       (push),
      .push_event (push_event)
   );

   rtis_queue u_queue (
      .clock      (clock),
      .reset      (reset),
      .push       (push),
      .push_event (push_event),
      .full       (queue_full),
      .pop        (pop),
      .head_valid (head_valid),
      .head_event (head_event)
   );

   rtis_back u_back (
      .clock      (clock),
      .reset      (reset),
      .head_valid (head_valid),
      .head_event (head_event),
      .pop        (pop),
      .rsp_valid  (rsp_valid),
      .rsp_stall  (rsp_stall),
      .rsp_totals (totals)
   );

   assign rsp_left_count = totals.count[KIND_LEFT];
   assign rsp_left_sum = totals.sum[KIND_LEFT];
   assign rsp_left_square_sum = totals.square_sum[KIND_LEFT];
   assign rsp_right_count = totals.count[KIND_RIGHT];
   assign rsp_right_sum = totals.sum[KIND_RIGHT];
   assign rsp_right_square_sum = totals.square_sum[KIND_RIGHT];
   assign rsp_center_count = totals.count[KIND_CENTER];
   assign rsp_center_sum = totals.sum[KIND_CENTER];
   assign rsp_center_square_sum = totals.square_sum[KIND_CENTER];

endmodule

`default_nettype wire

### rtl/rtis_front.sv
// ----------------------------------------------------------------------------
// rtis_front: pixel classification and tick run tracking
// Finds dark runs inside the row band, qualifies ticks and forms the three
// spacings to the previous tick of the row, then queues an event on a hit or frame end.
// ----------------------------------------------------------------------------
`default_nettype none

module rtis_front
   import rtis_pkg::*;
(
   input  wire logic       clock,
   input  wire logic       reset,
   input  wire cfg_type    cfg,
   input  wire logic       accept,
   input  wire logic [7:0] red,
   input  wire logic [7:0] green,
   input  wire logic [7:0] blue,
   input  wire logic [11:0] column,
   input  wire logic [11:0] row,
   input  wire logic       row_last,
   input  wire logic       frame_last,
   output logic            push,
   output event_type       push_event
);

   logic        in_run_ff, in_run_in;
   logic [11:0] run_start_ff, run_start_in;
   logic        have_prev_ff, have_prev_in;
   logic [11:0] prev_start_ff, prev_start_in;
   logic [12:0] prev_end_ff, prev_end_in;
   logic [12:0] prev_esum_ff, prev_esum_in;

   logic        in_band;
   logic        dark;
   logic        row_end;
   logic        close_en;
   logic [11:0] close_start;
   logic [12:0] close_end;
   logic [12:0] close_esum;
   logic signed [13:0] run_width;
   logic        tick;
   logic        pair;
   logic signed [14:0] spacing_left;
   logic signed [14:0] spacing_right;
   logic signed [14:0] edge_diff;
   logic signed [14:0] spacing_center;
   logic signed [14:0] cut_min;
   logic signed [14:0] cut_max;

   always_comb begin
      in_band = (row >= cfg.band_first_row) && ({1'b0, row} < cfg.band_end_row) &&
                (32'(column) < 32'(MAX_COLUMNS)) && (32'(row) < 32'(MAX_ROWS));
      dark = in_band && (red < cfg.dark_threshold) && (green < cfg.dark_threshold) &&
             (blue < cfg.dark_threshold);
      row_end = row_last || frame_last;

      close_start = (dark && !in_run_ff) ? column : run_start_ff;
      close_en = (!dark && in_run_ff) || (row_end && dark);
      close_end = dark ? ({1'b0, column} + 13'd1) : {1'b0, column};
      close_esum = {1'b0, close_start} + close_end;

      run_width = $signed({1'b0, close_end}) - $signed({2'b00, close_start});
      tick = close_en && (run_width >= $signed({1'b0, cfg.width_min})) &&
             (run_width <= $signed({1'b0, cfg.width_max}));
      pair = tick && have_prev_ff;

      spacing_left = $signed({3'b000, close_start}) - $signed({3'b000, prev_start_ff});
      spacing_right = $signed({2'b00, close_end}) - $signed({2'b00, prev_end_ff});
      edge_diff = $signed({2'b00, close_esum}) - $signed({2'b00, prev_esum_ff});
      spacing_center = edge_diff >>> 1;
      cut_min = $signed({2'b00, cfg.spacing_min});
      cut_max = $signed({2'b00, cfg.spacing_max});

      push_event.frame_last = frame_last;
      push_event.hit[KIND_LEFT] = pair && (spacing_left > cut_min) &&
                                  (spacing_left < cut_max);
      push_event.hit[KIND_RIGHT] = pair && (spacing_right > cut_min) &&
                                   (spacing_right < cut_max);
      push_event.hit[KIND_CENTER] = pair && (spacing_center > cut_min) &&
                                    (spacing_center < cut_max);
      push_event.spacing[KIND_LEFT] = spacing_left[12:0];
      push_event.spacing[KIND_RIGHT] = spacing_right[12:0];
      push_event.spacing[KIND_CENTER] = spacing_center[12:0];
      push = accept && (frame_last || (|push_event.hit));

      in_run_in = in_run_ff;
      run_start_in = run_start_ff;
      have_prev_in = have_prev_ff;
      prev_start_in = prev_start_ff;
      prev_end_in = prev_end_ff;
      prev_esum_in = prev_esum_ff;
      if (accept) begin
         in_run_in = dark && !row_end;
         run_start_in = close_start;
         if (tick) begin
            have_prev_in = 1'b1;
            prev_start_in = close_start;
            prev_end_in = close_end;
            prev_esum_in = close_esum;
         end
         if (row_end) begin
            have_prev_in = 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         in_run_ff <= 1'b0;
         run_start_ff <= '0;
         have_prev_ff <= 1'b0;
         prev_start_ff <= '0;
         prev_end_ff <= '0;
         prev_esum_ff <= '0;
      end else begin
         in_run_ff <= in_run_in;
         run_start_ff <= run_start_in;
         have_prev_ff <= have_prev_in;
         prev_start_ff <= prev_start_in;
         prev_end_ff <= prev_end_in;
         prev_esum_ff <= prev_esum_in;
      end
   end

endmodule

`default_nettype wire

### rtl/rtis_queue.sv
// ----------------------------------------------------------------------------
// rtis_queue: short event queue between front and back
// Holds classified events so that the front and the back stall on their own.
// ----------------------------------------------------------------------------
`default_nettype none

module rtis_queue
   import rtis_pkg::*;
(
   input  wire logic      clock,
   input  wire logic      reset,
   input  wire logic      push,
   input  wire event_type push_event,
   output logic           full,
   input  wire logic      pop,
   output logic           head_valid,
   output event_type      head_event
);

   event_type              entry_ff [QUEUE_DEPTH];
   logic [QUEUE_PTR_W-1:0] wr_ptr_ff, wr_ptr_in;
   logic [QUEUE_PTR_W-1:0] rd_ptr_ff, rd_ptr_in;
   logic [QUEUE_PTR_W:0]   fill_ff, fill_in;
   logic                   do_push;
   logic                   do_pop;

   always_comb begin
      full = (fill_ff == (QUEUE_PTR_W + 1)'(QUEUE_DEPTH));
      head_valid = (fill_ff != '0);
      head_event = entry_ff[rd_ptr_ff];
      do_push = push && !full;
      do_pop = pop && head_valid;
      wr_ptr_in = do_push ? wr_ptr_ff + 1'b1 : wr_ptr_ff;
      rd_ptr_in = do_pop ? rd_ptr_ff + 1'b1 : rd_ptr_ff;
      fill_in = fill_ff;
      if (do_push && !do_pop) begin
         fill_in = fill_ff + 1'b1;
      end else if (do_pop && !do_push) begin
         fill_in = fill_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (do_push) begin
         entry_ff[wr_ptr_ff] <= push_event;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         fill_ff <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         fill_ff <= fill_in;
      end
   end

endmodule

`default_nettype wire

### rtl/rtis_back.sv
// ----------------------------------------------------------------------------
// rtis_back: spacing statistics accumulators
// Squares the accepted spacings, adds them to saturating totals and loads
// the result register at frame end, clearing the totals.
// ----------------------------------------------------------------------------
`default_nettype none

module rtis_back
   import rtis_pkg::*;
(
   input  wire logic      clock,
   input  wire logic      reset,
   input  wire logic      head_valid,
   input  wire event_type head_event,
   output logic           pop,
   output logic           rsp_valid,
   input  wire logic      rsp_stall,
   output totals_type     rsp_totals
);

   logic             s1_valid_ff, s1_valid_in;
   square_stage_type s1_ff, s1_in;
   logic             s1_advance;

   logic [KIND_COUNT-1:0][23:0] count_ff, count_in;
   logic [KIND_COUNT-1:0][35:0] sum_ff, sum_in;
   logic [KIND_COUNT-1:0][47:0] square_sum_ff, square_sum_in;
   totals_type                  totals_new;
   totals_type                  rsp_totals_ff, rsp_totals_in;
   logic                        rsp_valid_ff, rsp_valid_in;

   logic [24:0] count_wide [KIND_COUNT];
   logic [36:0] sum_wide [KIND_COUNT];
   logic [48:0] square_wide [KIND_COUNT];

   always_comb begin
      s1_advance = s1_valid_ff && !(s1_ff.frame_last && rsp_valid_ff && rsp_stall);
      pop = head_valid && (!s1_valid_ff || s1_advance);

      s1_valid_in = pop ? 1'b1 : (s1_advance ? 1'b0 : s1_valid_ff);
      s1_in = s1_ff;
      if (pop) begin
         s1_in.frame_last = head_event.frame_last;
         s1_in.hit = head_event.hit;
         s1_in.spacing = head_event.spacing;
         for (int k = 0; k < KIND_COUNT; k++) begin
            s1_in.square[k] = 26'(head_event.spacing[k]) * 26'(head_event.spacing[k]);
         end
      end

      for (int k = 0; k < KIND_COUNT; k++) begin
         count_wide[k] = {1'b0, count_ff[k]} + 25'(s1_ff.hit[k]);
         sum_wide[k] = {1'b0, sum_ff[k]} + (s1_ff.hit[k] ? 37'(s1_ff.spacing[k]) : 37'd0);
         square_wide[k] = {1'b0, square_sum_ff[k]} +
                          (s1_ff.hit[k] ? 49'(s1_ff.square[k]) : 49'd0);
         totals_new.count[k] = count_wide[k][24] ? '1 : count_wide[k][23:0];
         totals_new.sum[k] = sum_wide[k][36] ? '1 : sum_wide[k][35:0];
         totals_new.square_sum[k] = square_wide[k][48] ? '1 : square_wide[k][47:0];
      end

      count_in = count_ff;
      sum_in = sum_ff;
      square_sum_in = square_sum_ff;
      rsp_totals_in = rsp_totals_ff;
      rsp_valid_in = rsp_valid_ff && rsp_stall;
      if (s1_advance) begin
         if (s1_ff.frame_last) begin
            count_in = '0;
            sum_in = '0;
            square_sum_in = '0;
            rsp_totals_in = totals_new;
            rsp_valid_in = 1'b1;
         end else begin
            count_in = totals_new.count;
            sum_in = totals_new.sum;
            square_sum_in = totals_new.square_sum;
         end
      end

      rsp_valid = rsp_valid_ff;
      rsp_totals = rsp_totals_ff;
   end

   always_ff @(posedge clock) begin
      s1_ff <= s1_in;
      rsp_totals_ff <= rsp_totals_in;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
         rsp_valid_ff <= 1'b0;
         count_ff <= '0;
         sum_ff <= '0;
         square_sum_ff <= '0;
      end else begin
         s1_valid_ff <= s1_valid_in;
         rsp_valid_ff <= rsp_valid_in;
         count_ff <= count_in;
         sum_ff <= sum_in;
         square_sum_ff <= square_sum_in;
      end
   end

endmodule

`default_nettype wire

### tb/sv/tick_stats_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tick_stats_checker: prediction and comparison for ruler tick spacing totals
// Watches the register, pixel and result channels, keeps its own copy of the
// registers and run state, predicts the per-frame totals and compares each
// result transfer field by field with the oldest prediction.
// ----------------------------------------------------------------------------

module tick_stats_checker
   import rtis_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   input  logic        csr_valid,
   input  logic        csr_ready,
   input  logic [2:0]  csr_index,
   input  logic [12:0] csr_data,
   input  logic        req_valid,
   input  logic        req_stall,
   input  logic [7:0]  req_red,
   input  logic [7:0]  req_green,
   input  logic [7:0]  req_blue,
   input  logic [11:0] req_column,
   input  logic [11:0] req_row,
   input  logic        req_row_last,
   input  logic        req_frame_last,
   input  logic        rsp_valid,
   input  logic        rsp_stall,
   input  logic [23:0] rsp_left_count,
   input  logic [35:0] rsp_left_sum,
   input  logic [47:0] rsp_left_square_sum,
   input  logic [23:0] rsp_right_count,
   input  logic [35:0] rsp_right_sum,
   input  logic [47:0] rsp_right_square_sum,
   input  logic [23:0] rsp_center_count,
   input  logic [35:0] rsp_center_sum,
   input  logic [47:0] rsp_center_square_sum,
   output int          mismatches,
   output int          outstanding
);

   localparam longint unsigned COUNT_CAP  = 64'hFF_FFFF;
   localparam longint unsigned SUM_CAP    = 64'hF_FFFF_FFFF;
   localparam longint unsigned SQUARE_CAP = 64'hFFFF_FFFF_FFFF;

   cfg_type    cfg;
   logic       in_run;
   logic       have_previous;
   int         run_start;
   int         previous_start;
   int         previous_end;
   int         previous_edge_sum;
   totals_type running;
   totals_type totals_due [$];
   totals_type seen;
   int         faults = 0;

   function automatic string kind_name(int kind);
      case (kind)
         KIND_LEFT:  return "left";
         KIND_RIGHT: return "right";
         default:    return "center";
      endcase
   endfunction

   function automatic longint unsigned saturate_add(longint unsigned a, longint unsigned b,
                                                    longint unsigned cap);
      return (a >= cap || b >= cap - a) ? cap : a + b;
   endfunction

   function automatic void tally_spacing(int kind, int spacing);
      longint unsigned magnitude;
      if (spacing <= int'(cfg.spacing_min) || spacing >= int'(cfg.spacing_max)) return;
      magnitude = longint'(spacing);
      running.count[kind]      = 24'(saturate_add(running.count[kind], 1, COUNT_CAP));
      running.sum[kind]        = 36'(saturate_add(running.sum[kind], magnitude, SUM_CAP));
      running.square_sum[kind] = 48'(saturate_add(running.square_sum[kind],
                                                  magnitude * magnitude, SQUARE_CAP));
   endfunction

   function automatic void close_mark(int end_col);
      int width;
      int edge_sum;
      width    = end_col - run_start;
      edge_sum = run_start + end_col;
      in_run   = 1'b0;
      if (width < int'(cfg.width_min) || width > int'(cfg.width_max)) return;
      if (have_previous) begin
         tally_spacing(KIND_LEFT, run_start - previous_start);
         tally_spacing(KIND_RIGHT, end_col - previous_end);
         tally_spacing(KIND_CENTER, (edge_sum - previous_edge_sum) / 2);
      end
      have_previous     = 1'b1;
      previous_start    = run_start;
      previous_end      = end_col;
      previous_edge_sum = edge_sum;
   endfunction

   function automatic void track_pixel(logic [7:0] red, logic [7:0] green, logic [7:0] blue,
                                       logic [11:0] col, logic [11:0] row,
                                       logic row_end, logic frame_end);
      logic in_band;
      logic dark;
      in_band = row >= cfg.band_first_row && row < cfg.band_end_row &&
                int'(col) < MAX_COLUMNS && int'(row) < MAX_ROWS;
      dark = in_band && red < cfg.dark_threshold && green < cfg.dark_threshold &&
             blue < cfg.dark_threshold;
      if (dark) begin
         if (!in_run) begin
            in_run    = 1'b1;
            run_start = int'(col);
         end
      end else if (in_run) begin
         close_mark(int'(col));
      end
      if (row_end || frame_end) begin
         if (in_run) close_mark(int'(col) + 1);
         in_run        = 1'b0;
         have_previous = 1'b0;
      end
      if (frame_end) begin
         totals_due.insert(totals_due.size(), running);
         running = '0;
      end
   endfunction

   function automatic void write_setting(logic [2:0] index, logic [12:0] data);
      case (csr_index_type'(index))
         CSR_DARK_THRESHOLD: cfg.dark_threshold = data[7:0];
         CSR_BAND_FIRST_ROW: cfg.band_first_row = data[11:0];
         CSR_BAND_END_ROW:   cfg.band_end_row   = data;
         CSR_WIDTH_MIN:      cfg.width_min      = data;
         CSR_WIDTH_MAX:      cfg.width_max      = data;
         CSR_SPACING_MIN:    cfg.spacing_min    = data;
         CSR_SPACING_MAX:    cfg.spacing_max    = data;
         default: ;
      endcase
   endfunction

   function automatic void compare_totals(totals_type actual);
      totals_type want;
      want = totals_due.pop_front();
      for (int k = 0; k < KIND_COUNT; k++) begin
         if (actual.count[k] !== want.count[k]) begin
            $display("%0t: %s_count expected %0d actual %0d", $time, kind_name(k),
                     want.count[k], actual.count[k]);
            faults++;
         end
         if (actual.sum[k] !== want.sum[k]) begin
            $display("%0t: %s_sum expected %0d actual %0d", $time, kind_name(k),
                     want.sum[k], actual.sum[k]);
            faults++;
         end
         if (actual.square_sum[k] !== want.square_sum[k]) begin
            $display("%0t: %s_square_sum expected %0d actual %0d", $time, kind_name(k),
                     want.square_sum[k], actual.square_sum[k]);
            faults++;
         end
      end
   endfunction

   always @(posedge clock) begin
      if (reset) begin
         cfg               = '{8'd128, 12'd0, 13'd0, 13'd1, 13'd30, 13'd0, 13'd100};
         in_run            = 1'b0;
         have_previous     = 1'b0;
         run_start         = 0;
         previous_start    = 0;
         previous_end      = 0;
         previous_edge_sum = 0;
         running           = '0;
         totals_due.delete();
      end else begin
         if (csr_valid && csr_ready) write_setting(csr_index, csr_data);
         if (rsp_valid && !rsp_stall) begin
            seen.count[KIND_LEFT]        = rsp_left_count;
            seen.sum[KIND_LEFT]          = rsp_left_sum;
            seen.square_sum[KIND_LEFT]   = rsp_left_square_sum;
            seen.count[KIND_RIGHT]       = rsp_right_count;
            seen.sum[KIND_RIGHT]         = rsp_right_sum;
            seen.square_sum[KIND_RIGHT]  = rsp_right_square_sum;
            seen.count[KIND_CENTER]      = rsp_center_count;
            seen.sum[KIND_CENTER]        = rsp_center_sum;
            seen.square_sum[KIND_CENTER] = rsp_center_square_sum;
            if (totals_due.size() == 0) begin
               $display("%0t: result transfer expected none actual left_count %0d",
                        $time, rsp_left_count);
               faults++;
            end else begin
               compare_totals(seen);
            end
         end
         if (req_valid && !req_stall)
            track_pixel(req_red, req_green, req_blue, req_column, req_row,
                        req_row_last, req_frame_last);
      end
      mismatches  <= faults;
      outstanding <= totals_due.size();
   end

endmodule

### tb/sv/tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb: stimulus and verdict for ruler tick spacing statistics
// Writes register settings between frames, sends directed pixel rows and then
// random frames of dark and light runs mixed with random pixels, with random
// gaps on the pixel side and random stalls on the result side. The checker
// beside the block predicts and compares every frame's totals.
// ----------------------------------------------------------------------------

module tb;
   import rtis_pkg::*;

   localparam int IDLE_LIMIT    = 1000;
   localparam int SETTLE_CYCLES = 8;
   localparam int PIXEL_GOAL    = 800;
   localparam int FRAME_GOAL    = 20;

   logic        clock = 1'b0;
   logic        reset;
   logic        csr_valid;
   logic        csr_ready;
   logic [2:0]  csr_index;
   logic [12:0] csr_data;
   logic        req_valid;
   logic        req_stall;
   logic [7:0]  req_red;
   logic [7:0]  req_green;
   logic [7:0]  req_blue;
   logic [11:0] req_column;
   logic [11:0] req_row;
   logic        req_row_last;
   logic        req_frame_last;
   logic        rsp_valid;
   logic        rsp_stall;
   logic [23:0] rsp_left_count;
   logic [35:0] rsp_left_sum;
   logic [47:0] rsp_left_square_sum;
   logic [23:0] rsp_right_count;
   logic [35:0] rsp_right_sum;
   logic [47:0] rsp_right_square_sum;
   logic [23:0] rsp_center_count;
   logic [35:0] rsp_center_sum;
   logic [47:0] rsp_center_square_sum;
   int          mismatches;
   int          outstanding;

   cfg_type setting;
   bit      sender_calm   = 1'b0;
   bit      receiver_calm = 1'b0;
   int      stall_hold    = 2;
   int      idle_cycles   = 0;
   int      pixels_sent   = 0;
   int      frames_sent   = 0;

   always #5 clock = ~clock;

   ruler_tick_interval_stats_top dut (.*);

   tick_stats_checker checker_0 (.*);

   always @(posedge clock) begin
      if (rsp_valid && !rsp_stall) begin
         if ($urandom_range(0, 3) == 0) receiver_calm = !receiver_calm;
         stall_hold = receiver_calm ? 0 : $urandom_range(0, 14);
      end else if (rsp_valid && stall_hold > 0) begin
         stall_hold = stall_hold - 1;
      end
      rsp_stall <= (stall_hold > 0);
   end

   always @(posedge clock) begin
      if ((req_valid && !req_stall) || (rsp_valid && !rsp_stall) || (csr_valid && csr_ready))
         idle_cycles <= 0;
      else
         idle_cycles <= idle_cycles + 1;
      if (idle_cycles >= IDLE_LIMIT) begin
         $display("Test completed with failures");
         $finish;
      end
   end

   task automatic write_reg(csr_index_type index, logic [12:0] value);
      csr_valid <= 1'b1;
      csr_index <= index;
      csr_data  <= value;
      do @(posedge clock); while (!csr_ready);
   endtask

   task automatic apply_setting();
      write_reg(CSR_DARK_THRESHOLD, 13'(setting.dark_threshold));
      write_reg(CSR_BAND_FIRST_ROW, 13'(setting.band_first_row));
      write_reg(CSR_BAND_END_ROW, setting.band_end_row);
      write_reg(CSR_WIDTH_MIN, setting.width_min);
      write_reg(CSR_WIDTH_MAX, setting.width_max);
      write_reg(CSR_SPACING_MIN, setting.spacing_min);
      write_reg(CSR_SPACING_MAX, setting.spacing_max);
      csr_valid <= 1'b0;
   endtask

   task automatic send_item(logic [7:0] red, logic [7:0] green, logic [7:0] blue,
                            logic [11:0] col, logic [11:0] row, logic row_end,
                            logic frame_end);
      int gap;
      gap = sender_calm ? 0 : $urandom_range(0, 14);
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_valid      <= 1'b1;
      req_red        <= red;
      req_green      <= green;
      req_blue       <= blue;
      req_column     <= col;
      req_row        <= row;
      req_row_last   <= row_end;
      req_frame_last <= frame_end;
      do @(posedge clock); while (req_stall);
      pixels_sent++;
   endtask

   task automatic send_pixel(bit dark, int col, int row, bit row_end, bit frame_end);
      logic [7:0] ch [3];
      int         thr;
      int         pick;
      thr = int'(setting.dark_threshold);
      if (dark && thr > 0) begin
         for (int k = 0; k < 3; k++) ch[k] = 8'($urandom_range(0, thr - 1));
      end else begin
         for (int k = 0; k < 3; k++) ch[k] = 8'($urandom_range(0, 255));
         pick = $urandom_range(0, 2);
         ch[pick] = 8'($urandom_range(thr, 255));
      end
      send_item(ch[0], ch[1], ch[2], 12'(col), 12'(row), row_end, frame_end);
   endtask

   task automatic send_noise();
      send_item(8'($urandom_range(0, 255)), 8'($urandom_range(0, 255)),
                8'($urandom_range(0, 255)),
                12'($urandom_range(0, 4095)), 12'($urandom_range(0, 4095)),
                $urandom_range(0, 7) == 0, $urandom_range(0, 15) == 0);
   endtask

   task automatic send_frame();
      int  width;
      int  height;
      int  base_col;
      int  base_row;
      int  left;
      bit  dark;
      width  = $urandom_range(6, 32);
      height = $urandom_range(1, 3);
      case ($urandom_range(0, 2))
         0:       base_col = 0;
         1:       base_col = 4096 - width;
         default: base_col = $urandom_range(0, 4096 - width);
      endcase
      base_row = int'(setting.band_first_row) - $urandom_range(0, 1);
      if (base_row < 0) base_row = 0;
      if (base_row > 4096 - height) base_row = 4096 - height;
      for (int y = 0; y < height; y++) begin
         dark = 1'($urandom_range(0, 1));
         left = $urandom_range(1, 4);
         for (int x = 0; x < width; x++) begin
            if (left == 0) begin
               dark = !dark;
               left = dark ? $urandom_range(1, 12) : $urandom_range(1, 10);
            end
            left--;
            send_pixel(dark, base_col + x, base_row + y, x == width - 1,
                       x == width - 1 && y == height - 1);
         end
      end
      frames_sent++;
   endtask

   task automatic drain();
      req_valid <= 1'b0;
      @(posedge clock);
      while (outstanding != 0) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   task automatic randomize_setting();
      int last;
      setting.dark_threshold = 8'($urandom_range(40, 220));
      setting.band_first_row = 12'($urandom_range(0, 4095));
      last = int'(setting.band_first_row) + $urandom_range(0, 5);
      setting.band_end_row = (last > 4096) ? 13'd4096 : 13'(last);
      setting.width_min = 13'($urandom_range(0, 3));
      setting.width_max = ($urandom_range(0, 3) == 0) ? 13'($urandom_range(0, 4))
                                                      : 13'($urandom_range(4, 20));
      setting.spacing_min = 13'($urandom_range(0, 8));
      setting.spacing_max = ($urandom_range(0, 7) == 0) ? 13'($urandom_range(0, 10))
                                                        : 13'($urandom_range(20, 120));
   endtask

   initial begin
      int phase;
      reset          <= 1'b1;
      csr_valid      <= 1'b0;
      csr_index      <= CSR_DARK_THRESHOLD;
      csr_data       <= '0;
      req_valid      <= 1'b0;
      req_red        <= '0;
      req_green      <= '0;
      req_blue       <= '0;
      req_column     <= '0;
      req_row        <= '0;
      req_row_last   <= 1'b0;
      req_frame_last <= 1'b0;
      setting = '{8'd128, 12'd0, 13'd0, 13'd1, 13'd30, 13'd0, 13'd100};
      repeat (11) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // After reset the band is empty, so a dark pixel gives zero totals.
      send_item(8'd0, 8'd0, 8'd0, 12'd0, 12'd0, 1'b1, 1'b1);
      drain();

      setting = '{8'd128, 12'd0, 13'd4096, 13'd1, 13'd30, 13'd0, 13'd100};
      apply_setting();
      send_item(8'd255, 8'd255, 8'd255, 12'd0, 12'd0, 1'b0, 1'b0);
      send_item(8'd0, 8'd0, 8'd0, 12'd1, 12'd0, 1'b0, 1'b0);
      send_item(8'd127, 8'd127, 8'd127, 12'd2, 12'd0, 1'b0, 1'b0);
      send_item(8'd0, 8'd0, 8'd128, 12'd3, 12'd0, 1'b0, 1'b0);
      send_item(8'd0, 8'd0, 8'd0, 12'd4, 12'd0, 1'b0, 1'b0);
      send_item(8'd1, 8'd2, 8'd3, 12'd5, 12'd0, 1'b0, 1'b0);
      send_item(8'd0, 8'd0, 8'd0, 12'd6, 12'd0, 1'b0, 1'b0);
      send_item(8'd128, 8'd0, 8'd0, 12'd7, 12'd0, 1'b0, 1'b0);
      send_item(8'd0, 8'd0, 8'd0, 12'd9, 12'd0, 1'b1, 1'b0);
      // Ticks placed right to left give negative spacings; a run that ends
      // below its start has negative width.
      send_item(8'd0, 8'd0, 8'd0, 12'd20, 12'd1, 1'b0, 1'b0);
      send_item(8'd255, 8'd0, 8'd0, 12'd22, 12'd1, 1'b0, 1'b0);
      send_item(8'd0, 8'd0, 8'd0, 12'd5, 12'd1, 1'b0, 1'b0);
      send_item(8'd0, 8'd255, 8'd0, 12'd7, 12'd1, 1'b0, 1'b0);
      send_item(8'd0, 8'd0, 8'd0, 12'd30, 12'd1, 1'b0, 1'b0);
      send_item(8'd0, 8'd0, 8'd255, 12'd3, 12'd1, 1'b0, 1'b0);
      send_item(8'd0, 8'd0, 8'd0, 12'd4095, 12'd1, 1'b1, 1'b0);
      send_item(8'd255, 8'd255, 8'd255, 12'd0, 12'd4095, 1'b0, 1'b0);
      send_item(8'd0, 8'd0, 8'd0, 12'd4094, 12'd4095, 1'b0, 1'b0);
      send_item(8'd0, 8'd0, 8'd0, 12'd4095, 12'd4095, 1'b1, 1'b1);
      drain();

      phase = 0;
      while (pixels_sent < PIXEL_GOAL || frames_sent < FRAME_GOAL) begin
         case (phase)
            0:       setting = '{8'd255, 12'd4095, 13'd4096, 13'd0, 13'd4096, 13'd0, 13'd4096};
            1:       setting = '{8'd0, 12'd0, 13'd4096, 13'd1, 13'd30, 13'd0, 13'd100};
            2:       setting = '{8'd200, 12'd0, 13'd4096, 13'd20, 13'd2, 13'd50, 13'd51};
            3:       setting = '{8'd128, 12'd0, 13'd4096, 13'd1, 13'd12, 13'd0, 13'd60};
            default: randomize_setting();
         endcase
         apply_setting();
         repeat ($urandom_range(2, 5)) begin
            sender_calm = ($urandom_range(0, 3) == 0);
            if ($urandom_range(0, 2) == 0) repeat ($urandom_range(1, 6)) send_noise();
            send_frame();
            if ($urandom_range(0, 4) == 0) drain();
         end
         drain();
         phase++;
      end

      if (mismatches == 0)
         $display("Test completed successfully");
      else
         $display("Test completed with failures");
      $finish;
   end

endmodule

### ruler_tick_interval_stats_top.f
rtl/rtis_pkg.sv
rtl/rtis_front.sv
rtl/rtis_queue.sv
rtl/rtis_back.sv
rtl/ruler_tick_interval_stats_top.sv
tb/sv/tick_stats_checker.sv
tb/sv/tb.sv
